FILE: hdl/blcg_pkg.sv
`timescale 1ns / 1ps

package blcg_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_HUE        = 2'd0;
    localparam logic [1:0] REG_SATURATION = 2'd1;
    localparam logic [1:0] REG_FLOOR      = 2'd2;

    localparam logic [7:0] HUE_RESET   = 8'd170;
    localparam logic [7:0] SAT_RESET   = 8'd255;
    localparam logic [7:0] FLOOR_RESET = 8'd80;
    localparam logic [7:0] CHANNEL_MAX = 8'd255;

    // n / 3 == (n * 21846) >> 16 for any n below 2^15
    localparam logic [14:0] THIRD_RECIP = 15'd21846;

    // hue regions around the color wheel
    localparam logic [2:0] REGION_RED     = 3'd0;
    localparam logic [2:0] REGION_YELLOW  = 3'd1;
    localparam logic [2:0] REGION_GREEN   = 3'd2;
    localparam logic [2:0] REGION_CYAN    = 3'd3;
    localparam logic [2:0] REGION_BLUE    = 3'd4;
    localparam logic [2:0] REGION_MAGENTA = 3'd5;

    typedef struct packed {
        logic [2:0] region;
        logic       sat_zero;
        logic [7:0] p_mul;
        logic [7:0] q_mul;
        logic [7:0] t_mul;
    } hsv_terms_t;

    // Scale factors for p, q and t; they depend on hue and saturation only.
    function automatic hsv_terms_t calc_terms(input logic [7:0] h, input logic [7:0] s);
        logic [10:0] h6;
        logic [7:0]  frac;
        logic [15:0] s_frac;
        logic [15:0] s_inv;
        hsv_terms_t  terms;
        h6            = {3'b000, h} * 11'd6;
        frac          = h6[7:0];
        s_frac        = {8'd0, s} * {8'd0, frac};
        s_inv         = {8'd0, s} * {8'd0, CHANNEL_MAX - frac};
        terms.region   = h6[10:8];
        terms.sat_zero = (s == 8'd0);
        terms.p_mul    = CHANNEL_MAX - s;
        terms.q_mul    = CHANNEL_MAX - s_frac[15:8];
        terms.t_mul    = CHANNEL_MAX - s_inv[15:8];
        return terms;
    endfunction

endpackage

FILE: hdl/blcg_cfg_regs.sv
`timescale 1ns / 1ps

module blcg_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [blcg_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [blcg_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [blcg_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [7:0]                       floor_level,
    output blcg_pkg::hsv_terms_t             terms
);
    import blcg_pkg::*;

    logic [7:0] hue_reg;
    logic [7:0] sat_reg;
    logic [7:0] floor_reg;
    hsv_terms_t terms_reg;
    hsv_terms_t terms_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_reg   <= HUE_RESET;
            sat_reg   <= SAT_RESET;
            floor_reg <= FLOOR_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_HUE:        hue_reg   <= pwdata[7:0];
                REG_SATURATION: sat_reg   <= pwdata[7:0];
                REG_FLOOR:      floor_reg <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    // derived terms are registered and follow the registers in the next cycle
    assign terms_next = calc_terms(hue_reg, sat_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            terms_reg <= calc_terms(HUE_RESET, SAT_RESET);
        else
            terms_reg <= terms_next;
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_HUE:        prdata = {24'd0, hue_reg};
            REG_SATURATION: prdata = {24'd0, sat_reg};
            REG_FLOOR:      prdata = {24'd0, floor_reg};
            default:        prdata = '0;
        endcase
    end

    assign floor_level = floor_reg;
    assign terms       = terms_reg;

    a_region_range: assert property (@(posedge clk) disable iff (!rst_n)
        terms_reg.region <= REGION_MAGENTA)
        else $error("hue region out of range");

endmodule

FILE: hdl/blcg_brightness.sv
`timescale 1ns / 1ps

module blcg_brightness (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] time_ms,
    input  logic [7:0]  floor_level,
    output logic        lvl_valid,
    input  logic        lvl_ready,
    output logic [7:0]  level
);
    import blcg_pkg::*;

    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic [7:0] phase_reg, phase_next;
    logic [7:0] x2_reg, x2_next;
    logic [7:0] sq2_reg, sq2_next;
    logic [7:0] sq3_reg;
    logic [7:0] cu3_reg, cu3_next;
    logic [7:0] lvl_reg, lvl_next;

    logic [28:0] div_prod;
    logic [7:0]  folded;
    logic [15:0] sq_prod;
    logic [15:0] cu_prod;
    logic [9:0]  ease_diff;
    logic [8:0]  ease;
    logic [9:0]  lvl_sum;

    assign rdy4     = !vld4_reg || lvl_ready;
    assign rdy3     = !vld3_reg || rdy4;
    assign rdy2     = !vld2_reg || rdy3;
    assign rdy1     = !vld1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1: phase = (t / 12) mod 256, via (t >> 2) / 3
    assign div_prod   = {15'd0, time_ms[15:2]} * {14'd0, THIRD_RECIP};
    assign phase_next = div_prod[23:16];

    // stage 2: triangle fold, double, square
    assign folded   = phase_reg[7] ? (CHANNEL_MAX - phase_reg) : phase_reg;
    assign x2_next  = {folded[6:0], 1'b0};
    assign sq_prod  = {8'd0, x2_next} * {8'd0, x2_next};
    assign sq2_next = sq_prod[15:8];

    // stage 3: cube
    assign cu_prod  = {8'd0, sq2_reg} * {8'd0, x2_reg};
    assign cu3_next = cu_prod[15:8];

    // stage 4: (3sq - 2cu) / 2 + floor, saturated
    assign ease_diff = {2'b00, sq3_reg} + {1'b0, sq3_reg, 1'b0} - {1'b0, cu3_reg, 1'b0};
    assign ease      = ease_diff[9:1];
    assign lvl_sum   = {1'b0, ease} + {2'b00, floor_level};
    assign lvl_next  = (lvl_sum[9:8] != 2'b00) ? CHANNEL_MAX : lvl_sum[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) vld1_reg <= in_valid;
            if (rdy2) vld2_reg <= vld1_reg;
            if (rdy3) vld3_reg <= vld2_reg;
            if (rdy4) vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
            phase_reg <= phase_next;
        if (rdy2)
        begin
            x2_reg  <= x2_next;
            sq2_reg <= sq2_next;
        end
        if (rdy3)
        begin
            sq3_reg <= sq2_reg;
            cu3_reg <= cu3_next;
        end
        if (rdy4)
            lvl_reg <= lvl_next;
    end

    assign lvl_valid = vld4_reg;
    assign level     = lvl_reg;

    a_cube_le_square: assert property (@(posedge clk) disable iff (!rst_n)
        vld3_reg |-> (cu3_reg <= sq3_reg))
        else $error("cube term above square term");

    a_ease_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld3_reg |-> (ease <= 9'd128))
        else $error("eased wave above half scale");

endmodule

FILE: hdl/blcg_hsv.sv
`timescale 1ns / 1ps

module blcg_hsv (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 lvl_valid,
    output logic                 lvl_ready,
    input  logic [7:0]           level,
    input  blcg_pkg::hsv_terms_t terms,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [23:0]          rgb
);
    import blcg_pkg::*;

    logic        vld_reg;
    logic [23:0] rgb_reg, rgb_next;
    logic [15:0] p_prod, q_prod, t_prod;
    logic [7:0]  p, q, t;
    logic [7:0]  r, g, b;

    assign lvl_ready = !vld_reg || out_ready;

    assign p_prod = {8'd0, level} * {8'd0, terms.p_mul};
    assign q_prod = {8'd0, level} * {8'd0, terms.q_mul};
    assign t_prod = {8'd0, level} * {8'd0, terms.t_mul};
    assign p = p_prod[15:8];
    assign q = q_prod[15:8];
    assign t = t_prod[15:8];

    always_comb
    begin
        unique case (terms.region)
            REGION_RED:    begin r = level; g = t;     b = p;     end
            REGION_YELLOW: begin r = q;     g = level; b = p;     end
            REGION_GREEN:  begin r = p;     g = level; b = t;     end
            REGION_CYAN:   begin r = p;     g = q;     b = level; end
            REGION_BLUE:   begin r = t;     g = p;     b = level; end
            default:       begin r = level; g = p;     b = q;     end
        endcase
        if (terms.sat_zero)
            rgb_next = {level, level, level};
        else
            rgb_next = {b, g, r};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (lvl_ready)
            vld_reg <= lvl_valid;
    end

    always_ff @(posedge clk)
    begin
        if (lvl_ready)
            rgb_reg <= rgb_next;
    end

    assign out_valid = vld_reg;
    assign rgb       = rgb_reg;

endmodule

FILE: hdl/breathing_led_color_generator_core.sv
// Throughput: one transaction per cycle; the 5-stage pipeline (divide, square, cube,
// level, HSV) takes a new timestamp every cycle while the output is taken.
// Reset (rst_n, async, active low) empties the pipeline and loads hue 170,
// saturation 255 and floor level 80.
`timescale 1ns / 1ps

module breathing_led_color_generator_core (
    input  logic                             clk,
    input  logic                             rst_n,
    // config port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [blcg_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [blcg_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [blcg_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    // timestamp stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // [15:0] time_ms
    // color stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);
    import blcg_pkg::*;

    logic [7:0] floor_level;
    hsv_terms_t terms;
    logic       lvl_valid;
    logic       lvl_ready;
    logic [7:0] level;

    // Register file; hue/saturation products are precomputed here so the
    // datapath only multiplies by the brightness.
    blcg_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .floor_level (floor_level),
        .terms       (terms)
    );

    // Stages 1-4: timestamp -> phase -> triangle -> cubic ease -> brightness.
    // Each stage holds its own valid bit, so bubbles fill in under backpressure.
    blcg_brightness u_bright (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .time_ms     (s_tdata),
        .floor_level (floor_level),
        .lvl_valid   (lvl_valid),
        .lvl_ready   (lvl_ready),
        .level       (level)
    );

    // Stage 5: p/q/t products, region select, output register.
    blcg_hsv u_hsv (
        .clk       (clk),
        .rst_n     (rst_n),
        .lvl_valid (lvl_valid),
        .lvl_ready (lvl_ready),
        .level     (level),
        .terms     (terms),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .rgb       (m_tdata)
    );

    // Input can only back up once the output register holds a result.
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

endmodule

FILE: tb/sv/blcg_color_checker.sv
`timescale 1ns / 1ps

// Scoreboard for the breathing LED core: mirrors the config registers from
// the APB writes, predicts one color per timestamp transaction and compares
// each color transaction against the oldest prediction.
module blcg_color_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [blcg_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [blcg_pkg::CFG_DATA_W-1:0]  pwdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // [15:0] time_ms
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [23:0]                      m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output int unsigned                      mismatch_count,
    output int unsigned                      outstanding
);

    import blcg_pkg::*;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    logic [7:0] hue_q;
    logic [7:0] sat_q;
    logic [7:0] floor_q;
    rgb_t       colors_due[$];

    // eased triangle brightness, then integer HSV to RGB
    function automatic rgb_t shade_of(input logic [15:0] stamp, input logic [7:0] hue_v,
                                      input logic [7:0] sat_v, input logic [7:0] floor_v);
        int unsigned phase;
        int unsigned sq;
        int unsigned cu;
        int unsigned lvl;
        int unsigned h6;
        int unsigned frac;
        int unsigned p;
        int unsigned q;
        int unsigned t;
        logic [2:0]  region;
        rgb_t        c;
        phase = (int'(stamp) / 12) & 255;
        if (phase >= 128)
            phase = 255 - phase;
        phase = (phase << 1) & 255;
        sq    = (phase * phase) >> 8;
        cu    = (sq * phase) >> 8;
        lvl   = (3 * sq - 2 * cu) / 2 + int'(floor_v);
        if (lvl > 255)
            lvl = 255;
        if (sat_v == 8'd0)
        begin
            c.red   = lvl[7:0];
            c.green = lvl[7:0];
            c.blue  = lvl[7:0];
            return c;
        end
        h6     = int'(hue_v) * 6;
        region = h6[10:8];
        frac   = h6 & 255;
        p = (lvl * (255 - int'(sat_v))) >> 8;
        q = (lvl * (255 - ((int'(sat_v) * frac) >> 8))) >> 8;
        t = (lvl * (255 - ((int'(sat_v) * (255 - frac)) >> 8))) >> 8;
        case (region)
            REGION_RED:    begin c.red = lvl[7:0]; c.green = t[7:0];   c.blue = p[7:0];   end
            REGION_YELLOW: begin c.red = q[7:0];   c.green = lvl[7:0]; c.blue = p[7:0];   end
            REGION_GREEN:  begin c.red = p[7:0];   c.green = lvl[7:0]; c.blue = t[7:0];   end
            REGION_CYAN:   begin c.red = p[7:0];   c.green = q[7:0];   c.blue = lvl[7:0]; end
            REGION_BLUE:   begin c.red = t[7:0];   c.green = p[7:0];   c.blue = lvl[7:0]; end
            default:       begin c.red = lvl[7:0]; c.green = p[7:0];   c.blue = q[7:0];   end
        endcase
        return c;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rgb_t want;
        rgb_t got;
        if (!rst_n)
        begin
            hue_q          <= HUE_RESET;
            sat_q          <= SAT_RESET;
            floor_q        <= FLOOR_RESET;
            colors_due.delete();
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_HUE:        hue_q   <= pwdata[7:0];
                    REG_SATURATION: sat_q   <= pwdata[7:0];
                    REG_FLOOR:      floor_q <= pwdata[7:0];
                    default:        ;   // unmapped address, write dropped
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (colors_due.size() == 0)
                begin
                    $error("color transaction with none expected: %h", m_tdata);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = colors_due.pop_front();
                    if (got.red !== want.red)
                        $error("red: expected %0d, actual %0d", want.red, got.red);
                    if (got.green !== want.green)
                        $error("green: expected %0d, actual %0d", want.green, got.green);
                    if (got.blue !== want.blue)
                        $error("blue: expected %0d, actual %0d", want.blue, got.blue);
                    if (got !== want)
                        mismatch_count <= mismatch_count + 1;
                end
            end
            if (s_tvalid && s_tready)
                colors_due.push_back(shade_of(s_tdata, hue_q, sat_q, floor_q));
            outstanding <= colors_due.size();
        end
    end

endmodule

FILE: tb/sv/breathing_led_color_generator_core_test.sv
`timescale 1ns / 1ps

// Top of the breathing LED core testbench: clock, reset, APB writes and the
// timestamp/color stream traffic. All prediction lives in blcg_color_checker.
module breathing_led_color_generator_core_test;

    import blcg_pkg::*;

    // unmapped register slot, used to prove stray writes are dropped
    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam int         PHASE_ITEMS = 64;
    localparam int         CYCLE_LIMIT = 400000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [15:0]            s_tdata;    // [15:0] time_ms
    logic                   m_tvalid;
    logic                   m_tready;
    logic [23:0]            m_tdata;    // [7:0] red, [15:8] green, [23:16] blue

    int unsigned mismatch_count;
    int unsigned outstanding;
    int unsigned cycle_count = 0;
    // when set, that side runs back to back with no idle cycles
    bit          send_burst  = 1'b0;
    bit          take_burst  = 1'b0;

    always #4 clk = ~clk;

    breathing_led_color_generator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    blcg_color_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("breathing_led_color_generator_core_test failed");
            $finish;
        end
    end

    // setup cycle, access cycle; register lands at the access edge.
    // Upper data bits are random: the core only keeps the low byte.
    task automatic apb_write(input logic [1:0] idx, input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one timestamp transaction, with a random idle gap in front
    task automatic send_stamp(input logic [15:0] stamp);
        int unsigned gap;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= stamp;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // drop valid and hold off until every predicted color has come back
    task automatic drain;
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // program all three registers, then stream random timestamps
    task automatic run_phase(input logic [7:0] hue_v, input logic [7:0] sat_v,
                             input logic [7:0] floor_v);
        apb_write(REG_HUE, hue_v);
        apb_write(REG_SATURATION, sat_v);
        apb_write(REG_FLOOR, floor_v);
        send_burst = ($urandom_range(0, 3) == 0);
        take_burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            // occasional full drain mid-phase
            if ($urandom_range(0, 39) == 0)
                drain();
            send_stamp(16'($urandom_range(0, 65535)));
        end
        drain();
    endtask

    // color sink: random stall before each transaction
    initial
    begin
        int unsigned stall;
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = take_burst ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        rst_n    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed timestamps at reset settings: ends of the range, the /12
        // boundaries, the fold around phase 128 and the 8-bit phase wrap.
        send_stamp(16'd0);
        send_stamp(16'd11);
        send_stamp(16'd12);
        send_stamp(16'd767);
        send_stamp(16'd768);
        send_stamp(16'd1524);
        send_stamp(16'd1535);
        send_stamp(16'd1536);
        send_stamp(16'd1548);
        send_stamp(16'd3071);
        send_stamp(16'd3072);
        send_stamp(16'h5555);
        send_stamp(16'hAAAA);
        send_stamp(16'hFFFF);
        drain();

        // one preset per hue region; zero saturation; brightness clipped at 255
        run_phase(8'd0,   8'd255, 8'd0);
        run_phase(8'd43,  8'd255, 8'd255);
        // stray write to the unmapped slot must not disturb anything
        apb_write(REG_UNUSED, 8'($urandom));
        run_phase(8'd86,  8'd128, 8'd200);
        run_phase(8'd128, 8'd0,   8'd80);
        run_phase(8'd171, 8'd1,   8'd127);
        run_phase(8'd214, 8'd254, 8'd0);
        run_phase(8'd255, 8'd255, 8'd255);
        run_phase(8'd170, 8'd0,   8'd255);

        repeat (5)
            run_phase(8'($urandom), 8'($urandom), 8'($urandom));

        // pipeline is five deep; give stragglers a chance to show up
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("breathing_led_color_generator_core_test passed");
        else
            $display("breathing_led_color_generator_core_test failed");
        $finish;
    end

endmodule
